// ===== src/bclru_pkg.sv =====
// Shared widths, status and request codes for the block cache LRU controller.
// No dependencies; used by the channel interfaces and the top level.
package bclru_pkg;

  localparam int KIND_W      = 2;
  localparam int BLK_W       = 16;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 6;
  localparam int CFG_W       = 7;
  localparam int STAMP_W     = 32;

  // Results per request are capped here, which also caps the active slots.
  localparam int MAX_RESULTS   = 64;
  localparam int SLOTS_DEFAULT = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITEBACK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_DIRTY = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_ZERO   = 3'd6;

endpackage

// ===== src/bclru_req_if.sv =====
// Request channel: valid/ready plus request kind and block number.
// Depends on bclru_pkg.
interface bclru_req_if;
  logic                         valid;
  logic                         ready;
  logic [bclru_pkg::KIND_W-1:0] kind;
  logic [bclru_pkg::BLK_W-1:0]  block_number;

  modport source (output valid, kind, block_number, input ready);
  modport sink   (input valid, kind, block_number, output ready);
endinterface

// ===== src/bclru_rsp_if.sv =====
// Result channel: valid/ready plus status, slot, block, evicted and last.
// Depends on bclru_pkg.
interface bclru_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bclru_pkg::STATUS_W-1:0] status;
  logic [bclru_pkg::SLOT_W-1:0]   slot;
  logic [bclru_pkg::BLK_W-1:0]    block_out;
  logic                           evicted;
  logic                           last;

  modport source (output valid, status, slot, block_out, evicted, last, input ready);
  modport sink   (input valid, status, slot, block_out, evicted, last, output ready);
endinterface

// ===== src/block_cache_lru_clean_victim.sv =====
// Top level of the fully associative block cache tag/LRU controller.
// Depends on bclru_pkg, bclru_req_if and bclru_rsp_if.
//
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    kind[1:0], block_number[15:0]
// rsp       out  valid/ready    status[2:0], slot[5:0], block_out[15:0], evicted, last
// cfg       in   cfg_we         cfg_wdata[6:0] -> slots_in_use
//
// Get/mark: the scan over the n active slots feeds one slot per
//   cycle through the shared age subtract/compare unit behind the tag RAM read.
// Flush: each write-back waits for the output register to free up.
//   Block zero: get/mark skip the scan and go straight to the result stage.
// req.ready is high only in idle; a held result does not block the next accept.
// Reset clears valid and dirty flops; tag and stamp RAMs get no pass.
module block_cache_lru_clean_victim #(
  parameter int SLOTS = bclru_pkg::SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  bclru_req_if.sink                   req,
  bclru_rsp_if.source                 rsp,
  input  logic                        cfg_we,
  input  logic [bclru_pkg::CFG_W-1:0] cfg_wdata
);

  // Only the first MAX_RESULTS slots can ever be active.
  localparam int DEPTH = (SLOTS < bclru_pkg::MAX_RESULTS) ? SLOTS : bclru_pkg::MAX_RESULTS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_EMIT    = 3'd3;
  localparam logic [2:0] S_FL_SCAN = 3'd4;
  localparam logic [2:0] S_FL_DATA = 3'd5;

  logic [2:0] state;

  // configuration and active count
  logic [bclru_pkg::CFG_W-1:0] slots_in_use;
  logic [bclru_pkg::CFG_W-1:0] n_clamp;
  logic [CNT_W-1:0]            n_act;

  // latched request
  logic [bclru_pkg::KIND_W-1:0]  op_kind;
  logic [bclru_pkg::BLK_W-1:0]   op_blk;
  logic [bclru_pkg::STAMP_W-1:0] access_counter;

  // per-slot flops and RAMs
  logic [DEPTH-1:0]              slot_valid;
  logic [DEPTH-1:0]              slot_dirty;
  logic [bclru_pkg::BLK_W-1:0]   mem_block [DEPTH];
  logic [bclru_pkg::STAMP_W-1:0] mem_stamp [DEPTH];
  logic [bclru_pkg::BLK_W-1:0]   rd_block;
  logic [bclru_pkg::STAMP_W-1:0] rd_stamp;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              wr_addr;
  logic                          we_blk;
  logic                          we_stamp;

  // scan sequencer
  logic [CNT_W-1:0]              idx;
  logic [IDX_W-1:0]              idx_lo;
  logic                          idx_in_range;
  logic                          pend;
  logic [IDX_W-1:0]              pend_idx;
  logic                          hit_found;
  logic [IDX_W-1:0]              hit_idx;
  logic                          empty_found;
  logic [IDX_W-1:0]              empty_idx;
  logic                          cand_found;
  logic [IDX_W-1:0]              cand_idx;
  logic [bclru_pkg::STAMP_W-1:0] best_age;
  logic [bclru_pkg::STAMP_W-1:0] age;
  logic [IDX_W-1:0]              tgt_idx;

  // pending result and held write-back (flush looks one dirty slot ahead for last)
  logic [bclru_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]               res_slot;
  logic [bclru_pkg::BLK_W-1:0]    res_blk;
  logic                           res_ev;
  logic                           res_last;
  logic                           held_valid;
  logic [IDX_W-1:0]               held_slot;
  logic [bclru_pkg::BLK_W-1:0]    held_blk;

  // output register
  logic                           out_valid;
  logic                           out_free;
  logic                           out_load;

  // Active count: zero reads as one, capped at the slot depth.
  always_comb begin
    if (slots_in_use == '0) begin
      n_clamp = 7'd1;
    end else if (slots_in_use > 7'(DEPTH)) begin
      n_clamp = 7'(DEPTH);
    end else begin
      n_clamp = slots_in_use;
    end
    n_act = CNT_W'(n_clamp);
  end

  assign idx_lo       = idx[IDX_W-1:0];
  assign idx_in_range = (idx < n_act);
  assign rd_addr      = idx_in_range ? idx_lo : '0;

  // Shared age unit: one subtract per scanned slot.
  assign age     = access_counter - rd_stamp;
  assign tgt_idx = empty_found ? empty_idx : cand_idx;

  // RAM writes happen only in the decide cycle.
  always_comb begin
    we_blk   = 1'b0;
    we_stamp = 1'b0;
    wr_addr  = hit_found ? hit_idx : tgt_idx;
    if (state == S_DECIDE) begin
      we_blk   = !hit_found && (op_kind == bclru_pkg::KIND_GET) &&
                 (empty_found || cand_found);
      we_stamp = hit_found || we_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (we_blk) begin
      mem_block[wr_addr] <= op_blk;
    end
    if (we_stamp) begin
      mem_stamp[wr_addr] <= access_counter;
    end
    rd_block <= mem_block[rd_addr];
    rd_stamp <= mem_stamp[rd_addr];
  end

  assign out_free  = !out_valid || rsp.ready;
  assign out_load  = (state == S_EMIT) && out_free;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slots_in_use   <= bclru_pkg::CFG_RESET;
      access_counter <= '0;
      slot_valid     <= '0;
      slot_dirty     <= '0;
      out_valid      <= 1'b0;
      pend           <= 1'b0;
      held_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_wdata;
      end
      // a new result loaded in the same cycle keeps the register full
      if (rsp.valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_kind     <= req.kind;
            op_blk      <= req.block_number;
            idx         <= '0;
            pend        <= 1'b0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            cand_found  <= 1'b0;
            held_valid  <= 1'b0;
            priority if (req.kind == bclru_pkg::KIND_FLUSH) begin
              state <= S_FL_SCAN;
            end else if (req.kind == bclru_pkg::KIND_GET ||
                         req.kind == bclru_pkg::KIND_MARK) begin
              if (req.block_number == '0) begin
                res_status <= bclru_pkg::ST_BAD_ZERO;
                res_slot   <= '0;
                res_blk    <= '0;
                res_ev     <= 1'b0;
                res_last   <= 1'b1;
                state      <= S_EMIT;
              end else begin
                access_counter <= access_counter + 32'd1;
                state          <= S_SCAN;
              end
            end else begin
              state <= S_IDLE;  // reserved kind: dropped, no result
            end
          end
        end

        S_SCAN: begin
          // issue stage
          if (idx_in_range) begin
            idx      <= idx + 1'b1;
            pend     <= 1'b1;
            pend_idx <= idx_lo;
          end else begin
            pend <= 1'b0;
          end
          // data stage: hit, first empty, oldest clean
          if (pend) begin
            if (!hit_found && slot_valid[pend_idx] && rd_block == op_blk) begin
              hit_found <= 1'b1;
              hit_idx   <= pend_idx;
            end
            if (!empty_found && !slot_valid[pend_idx]) begin
              empty_found <= 1'b1;
              empty_idx   <= pend_idx;
            end
            if (slot_valid[pend_idx] && !slot_dirty[pend_idx] &&
                (!cand_found || age > best_age)) begin
              cand_found <= 1'b1;
              cand_idx   <= pend_idx;
              best_age   <= age;
            end
          end
          if (!idx_in_range && !pend) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          res_last <= 1'b1;
          res_ev   <= 1'b0;
          res_blk  <= op_blk;
          res_slot <= '0;
          if (hit_found) begin
            res_status <= bclru_pkg::ST_HIT;
            res_slot   <= hit_idx;
            if (op_kind == bclru_pkg::KIND_MARK) begin
              slot_dirty[hit_idx] <= 1'b1;
            end
          end else if (op_kind == bclru_pkg::KIND_MARK) begin
            res_status <= bclru_pkg::ST_ABSENT;
          end else if (empty_found || cand_found) begin
            res_status          <= bclru_pkg::ST_MISS;
            res_slot            <= tgt_idx;
            res_ev              <= !empty_found;
            slot_valid[tgt_idx] <= 1'b1;
            slot_dirty[tgt_idx] <= 1'b0;
          end else begin
            res_status <= bclru_pkg::ST_FULL;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            rsp.status    <= res_status;
            rsp.slot      <= bclru_pkg::SLOT_W'(res_slot);
            rsp.block_out <= res_blk;
            rsp.evicted   <= res_ev;
            rsp.last      <= res_last;
            out_valid     <= 1'b1;
            state         <= res_last ? S_IDLE : S_FL_SCAN;
          end
        end

        S_FL_SCAN: begin
          if (!idx_in_range) begin
            res_ev   <= 1'b0;
            res_last <= 1'b1;
            if (held_valid) begin
              res_status <= bclru_pkg::ST_WRITEBACK;
              res_slot   <= held_slot;
              res_blk    <= held_blk;
              held_valid <= 1'b0;
            end else begin
              res_status <= bclru_pkg::ST_NONE_DIRTY;
              res_slot   <= '0;
              res_blk    <= '0;
            end
            state <= S_EMIT;
          end else if (slot_dirty[idx_lo]) begin
            state <= S_FL_DATA;  // tag read for idx lands next cycle
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FL_DATA: begin
          slot_dirty[idx_lo] <= 1'b0;
          held_slot          <= idx_lo;
          held_blk           <= rd_block;
          held_valid         <= 1'b1;
          idx                <= idx + 1'b1;
          if (held_valid) begin
            res_status <= bclru_pkg::ST_WRITEBACK;
            res_slot   <= held_slot;
            res_blk    <= held_blk;
            res_ev     <= 1'b0;
            res_last   <= 1'b0;
            state      <= S_EMIT;
          end else begin
            state <= S_FL_SCAN;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Every accepted get/mark on a nonzero block advances the access clock by one.
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.block_number != '0 &&
     (req.kind == bclru_pkg::KIND_GET || req.kind == bclru_pkg::KIND_MARK))
    |=> access_counter == $past(access_counter) + 32'd1)
    else $error("access counter did not advance on get/mark");

  // A flush write-back only ever takes an occupied dirty slot.
  a_flush_dirty: assert property (@(posedge clk) disable iff (rst)
    state == S_FL_DATA |-> slot_dirty[idx_lo] && slot_valid[idx_lo])
    else $error("write-back of a clean or empty slot");

  // An eviction replaces an occupied clean slot.
  a_victim_clean: assert property (@(posedge clk) disable iff (rst)
    (we_blk && !empty_found) |-> slot_valid[cand_idx] && !slot_dirty[cand_idx])
    else $error("victim slot is dirty or empty");

  // A fill into a free slot never overwrites an occupied one.
  a_fill_empty: assert property (@(posedge clk) disable iff (rst)
    (we_blk && empty_found) |-> !slot_valid[empty_idx])
    else $error("fill target slot already occupied");
`endif

endmodule
